### rtl/kbd_pkg.sv
// shared types, scan codes and character tables for the keyboard scan code decoder
package kbd_pkg;

    localparam int unsigned SCAN_W = 8;
    localparam int unsigned KEY_W  = 7;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned MASK_W = 5;
    localparam int unsigned KIND_W = 2;

    // scan codes (set 1, make codes)
    localparam logic [SCAN_W-1:0] SC_PREFIX  = 8'hE0;
    localparam logic [KEY_W-1:0]  SC_LSHIFT  = 7'h2A;
    localparam logic [KEY_W-1:0]  SC_RSHIFT  = 7'h36;
    localparam logic [KEY_W-1:0]  SC_CAPS    = 7'h3A;
    localparam logic [KEY_W-1:0]  SC_LGUI    = 7'h5B;
    localparam logic [KEY_W-1:0]  SC_RGUI    = 7'h5C;
    localparam logic [KEY_W-1:0]  SC_CTRL    = 7'h1D;
    localparam logic [KEY_W-1:0]  SC_ALT     = 7'h38;
    localparam logic [KEY_W-1:0]  TABLE_LEN  = 7'd58;

    localparam logic [CHAR_W-1:0] GUI_CODE    = 8'hE0;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE = 2'd0,
        EV_CHAR = 2'd1,
        EV_GUI  = 2'd2
    } t_kind;

    // modifier mask bits
    localparam int unsigned MB_SHIFT = 0;
    localparam int unsigned MB_CAPS  = 1;
    localparam int unsigned MB_GUI   = 2;
    localparam int unsigned MB_CTRL  = 3;
    localparam int unsigned MB_ALT   = 4;

    // first member lands in the top bits, so kind ends up lowest
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [CHAR_W-1:0] code;
        t_kind             kind;
    } t_event;

    typedef struct packed {
        logic shift;
        logic caps;
    } t_case_ctl;

    function automatic logic [CHAR_W-1:0] plain_char(input logic [5:0] key);
        logic [CHAR_W-1:0] c;
        c = 8'h00;
        unique case (key)
            6'd1:  c = 8'd27;
            6'd2:  c = "1";
            6'd3:  c = "2";
            6'd4:  c = "3";
            6'd5:  c = "4";
            6'd6:  c = "5";
            6'd7:  c = "6";
            6'd8:  c = "7";
            6'd9:  c = "8";
            6'd10: c = "9";
            6'd11: c = "0";
            6'd12: c = "-";
            6'd13: c = "=";
            6'd14: c = 8'd8;
            6'd15: c = 8'd9;
            6'd16: c = "q";
            6'd17: c = "w";
            6'd18: c = "e";
            6'd19: c = "r";
            6'd20: c = "t";
            6'd21: c = "y";
            6'd22: c = "u";
            6'd23: c = "i";
            6'd24: c = "o";
            6'd25: c = "p";
            6'd26: c = "[";
            6'd27: c = "]";
            6'd28: c = 8'd10;
            6'd30: c = "a";
            6'd31: c = "s";
            6'd32: c = "d";
            6'd33: c = "f";
            6'd34: c = "g";
            6'd35: c = "h";
            6'd36: c = "j";
            6'd37: c = "k";
            6'd38: c = "l";
            6'd39: c = ";";
            6'd40: c = 8'd39;  // apostrophe
            6'd41: c = 8'd96;  // backquote
            6'd43: c = 8'd92;  // backslash
            6'd44: c = "z";
            6'd45: c = "x";
            6'd46: c = "c";
            6'd47: c = "v";
            6'd48: c = "b";
            6'd49: c = "n";
            6'd50: c = "m";
            6'd51: c = ",";
            6'd52: c = ".";
            6'd53: c = "/";
            6'd55: c = "*";
            6'd57: c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] upper_char(input logic [5:0] key);
        logic [CHAR_W-1:0] c;
        c = 8'h00;
        unique case (key)
            6'd1:  c = 8'd27;
            6'd2:  c = "!";
            6'd3:  c = "@";
            6'd4:  c = "#";
            6'd5:  c = "$";
            6'd6:  c = "%";
            6'd7:  c = "^";
            6'd8:  c = "&";
            6'd9:  c = "*";
            6'd10: c = "(";
            6'd11: c = ")";
            6'd12: c = "_";
            6'd13: c = "+";
            6'd14: c = 8'd8;
            6'd15: c = 8'd9;
            6'd16: c = "Q";
            6'd17: c = "W";
            6'd18: c = "E";
            6'd19: c = "R";
            6'd20: c = "T";
            6'd21: c = "Y";
            6'd22: c = "U";
            6'd23: c = "I";
            6'd24: c = "O";
            6'd25: c = "P";
            6'd26: c = "{";
            6'd27: c = "}";
            6'd28: c = 8'd10;
            6'd30: c = "A";
            6'd31: c = "S";
            6'd32: c = "D";
            6'd33: c = "F";
            6'd34: c = "G";
            6'd35: c = "H";
            6'd36: c = "J";
            6'd37: c = "K";
            6'd38: c = "L";
            6'd39: c = ":";
            6'd40: c = 8'd34;  // double quote
            6'd41: c = "~";
            6'd43: c = "|";
            6'd44: c = "Z";
            6'd45: c = "X";
            6'd46: c = "C";
            6'd47: c = "V";
            6'd48: c = "B";
            6'd49: c = "N";
            6'd50: c = "M";
            6'd51: c = "<";
            6'd52: c = ">";
            6'd53: c = "?";
            6'd55: c = "*";
            6'd57: c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### rtl/kbd_char_map.sv
// key number to character lookup with shift and caps lock handling
module kbd_char_map
    import kbd_pkg::*;
(
    input  logic [KEY_W-1:0]  i_key,
    input  t_case_ctl         i_ctl,
    output logic [CHAR_W-1:0] o_char
);

    logic [CHAR_W-1:0] base_char;

    always_comb begin
        base_char = 8'h00;
        if (i_key < TABLE_LEN) begin
            base_char = i_ctl.shift ? upper_char(i_key[5:0]) : plain_char(i_key[5:0]);
        end
    end

    // caps lock swaps the case of letters only
    always_comb begin
        o_char = base_char;
        if (i_ctl.caps) begin
            if (base_char >= "a" && base_char <= "z") begin
                o_char = base_char - CASE_OFFSET;
            end else if (base_char >= "A" && base_char <= "Z") begin
                o_char = base_char + CASE_OFFSET;
            end
        end
    end

endmodule

### rtl/kbd_decode.sv
// modifier flag registers and per-byte event decode
module kbd_decode
    import kbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SCAN_W-1:0] i_byte,
    input  logic              i_take,
    output t_event            o_event
);

    logic r_shift, r_caps, r_gui, r_ctrl, r_alt;
    logic n_shift, n_caps, n_gui, n_ctrl, n_alt;

    logic              rel;
    logic [KEY_W-1:0]  key;
    logic [CHAR_W-1:0] map_char;
    t_case_ctl         case_ctl;

    assign rel = i_byte[SCAN_W-1];
    assign key = i_byte[KEY_W-1:0];
    assign case_ctl = '{shift: r_shift, caps: r_caps};

    kbd_char_map u_char_map (
        .i_key  (key),
        .i_ctl  (case_ctl),
        .o_char (map_char)
    );

    // the extended prefix leaves decoding unchanged, so it needs no flag here
    always_comb begin
        n_shift = r_shift;
        n_caps  = r_caps;
        n_gui   = r_gui;
        n_ctrl  = r_ctrl;
        n_alt   = r_alt;
        o_event.kind = EV_NONE;
        o_event.code = '0;
        priority if (i_byte == SC_PREFIX) begin
            // prefix alone produces an empty event
        end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
            n_shift = !rel;
        end else if (key == SC_CAPS) begin
            if (!rel) begin
                n_caps = !r_caps;
            end
        end else if (key == SC_LGUI || key == SC_RGUI) begin
            n_gui = !rel;
            if (!rel) begin
                o_event.kind = EV_GUI;
                o_event.code = GUI_CODE;
            end
        end else if (key == SC_CTRL) begin
            n_ctrl = !rel;
        end else if (key == SC_ALT) begin
            n_alt = !rel;
        end else if (!rel && map_char != '0) begin
            o_event.kind = EV_CHAR;
            o_event.code = map_char;
        end else begin
            // release of a plain key or unmapped key
        end
        o_event.mask = '0;
        o_event.mask[MB_SHIFT] = n_shift;
        o_event.mask[MB_CAPS]  = n_caps;
        o_event.mask[MB_GUI]   = n_gui;
        o_event.mask[MB_CTRL]  = n_ctrl;
        o_event.mask[MB_ALT]   = n_alt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
            r_gui   <= 1'b0;
            r_ctrl  <= 1'b0;
            r_alt   <= 1'b0;
        end else if (i_take) begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
            r_gui   <= n_gui;
            r_ctrl  <= n_ctrl;
            r_alt   <= n_alt;
        end
    end

endmodule

### rtl/keyboard_scancode_decoder.sv
// top level of the set-1 keyboard scan code decoder
//
// usage
//   slave stream: one raw set-1 scan byte per request on i_s_axis_tdata
//   master stream: exactly one event per input byte, in input order
//     tdata[1:0] event kind (none, character, gui), tdata[9:2] key code,
//     tdata[14:10] modifier mask after the byte (shift, caps, gui, ctrl, alt)
//   the byte 0xe0 is an extended prefix; it gives an empty event and a
//   prefixed key decodes like its plain counterpart
// timing
//   an accepted byte is held in the input register, is decoded by the
//   table lookup and flag logic, and lands in the result register, where
//   the event is valid and can be taken by the receiver
//   throughput is one byte per cycle while tready stays high, set by the single decode stage
// reset
//   i_rst_n low (synchronous) clears all modifier flags and both valid bits
// stall
//   when the receiver holds tready low, the result register keeps its event
//   and the input register still takes one more byte; after that tready
//   on the slave side falls until the result is taken
module keyboard_scancode_decoder
    import kbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] scan_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [1:0] event_kind, [9:2] key_code,
                                          // [14:10] modifier_mask, [15] zero
);

    logic              r_in_valid;
    logic [SCAN_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_event            r_out_event;

    logic   out_free;
    logic   advance;
    t_event dec_event;

    // result register empty or being drained this cycle
    assign out_free = !r_out_valid || i_m_axis_tready;
    // the held byte moves through decode into the result register
    assign advance  = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    kbd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (r_in_byte),
        .i_take  (advance),
        .o_event (dec_event)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= dec_event;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_event};

endmodule

### rtl/kbd_checker.sv
// port-level checks for the keyboard scan code decoder, bound to the top level
module kbd_checker
    import kbd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // an empty event carries no code
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == EV_NONE |-> o_m_axis_tdata[9:2] == 8'h00)
        else $error("empty event with nonzero code");

    // a gui event carries the gui code and shows gui held
    a_gui_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == EV_GUI
            |-> o_m_axis_tdata[9:2] == GUI_CODE && o_m_axis_tdata[10 + MB_GUI])
        else $error("gui event malformed");

    // a byte accepted into an idle block passes the input register and shows up in the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid |=> ##1 o_m_axis_tvalid)
        else $error("result missing two cycles after request");

endmodule

bind keyboard_scancode_decoder kbd_checker u_kbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
